// File: hw/rtl/flv_pkg.sv
// Package for the float literal validator.
// Holds recogniser state codes, verdict codes and character constants.
// No dependencies.
package flv_pkg;

    typedef enum logic [3:0] {
        ST_START   = 4'd0,
        ST_SIGN    = 4'd1,
        ST_INT     = 4'd2,
        ST_DOT     = 4'd3,
        ST_FRAC    = 4'd4,
        ST_EXP     = 4'd5,
        ST_EXPSIGN = 4'd6,
        ST_EXPDIG  = 4'd7,
        ST_DEAD    = 4'd8
    } t_state;

    typedef logic [1:0] t_verdict;

    localparam t_verdict V_VALID      = 2'd0;
    localparam t_verdict V_INCOMPLETE = 2'd1;
    localparam t_verdict V_INVALID    = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_E_UC  = 8'h45;
    localparam logic [7:0] CH_E_LC  = 8'h65;

endpackage

// File: hw/rtl/float_literal_validator.sv
// Float literal validator: one character per item, verdict on the NUL item.
// A NUL item's verdict passes from the input register to the result register,
// which raises o_valid; a held verdict can stall it in the input register.
// Throughput: one item per cycle; the input register, recogniser state and
// result register form a single pass, stalled only by a held verdict.
// Reset (synchronous, active low) empties both registers and returns the
// recogniser to its start state. Depends on flv_pkg.
module float_literal_validator
    import flv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_character,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_verdict
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    t_verdict   r_verdict;
    t_verdict   n_verdict;

    logic advance;
    logic is_nul;
    logic is_digit;
    logic is_sign;
    logic is_dot;
    logic is_exp;

    assign is_nul   = (r_in_char == CH_NUL);
    assign is_digit = (r_in_char >= CH_ZERO) && (r_in_char <= CH_NINE);
    assign is_sign  = (r_in_char == CH_PLUS) || (r_in_char == CH_MINUS);
    assign is_dot   = (r_in_char == CH_DOT);
    assign is_exp   = (r_in_char == CH_E_UC) || (r_in_char == CH_E_LC);

    // only a NUL item needs room in the result register
    assign advance = r_in_valid && (!is_nul || !r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;

    always_comb begin
        n_state = ST_DEAD;
        case (r_state)
            ST_START: begin
                if (is_sign)       n_state = ST_SIGN;
                else if (is_digit) n_state = ST_INT;
                else if (is_dot)   n_state = ST_DOT;
            end
            ST_SIGN: begin
                if (is_digit)    n_state = ST_INT;
                else if (is_dot) n_state = ST_DOT;
            end
            ST_INT: begin
                if (is_digit)    n_state = ST_INT;
                else if (is_dot) n_state = ST_FRAC;
                else if (is_exp) n_state = ST_EXP;
            end
            ST_DOT: begin
                if (is_digit) n_state = ST_FRAC;
            end
            ST_FRAC: begin
                if (is_digit)    n_state = ST_FRAC;
                else if (is_exp) n_state = ST_EXP;
            end
            ST_EXP: begin
                if (is_sign)       n_state = ST_EXPSIGN;
                else if (is_digit) n_state = ST_EXPDIG;
            end
            ST_EXPSIGN, ST_EXPDIG: begin
                if (is_digit) n_state = ST_EXPDIG;
            end
            default: n_state = ST_DEAD;
        endcase
        if (is_nul) begin
            n_state = ST_START;
        end
    end

    always_comb begin
        case (r_state)
            ST_INT, ST_FRAC, ST_EXPDIG: n_verdict = V_VALID;
            ST_EXP, ST_EXPSIGN:         n_verdict = V_INCOMPLETE;
            default:                    n_verdict = V_INVALID;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= ST_START;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && is_nul) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_char <= i_character;
        end
        if (advance && is_nul) begin
            r_verdict <= n_verdict;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_verdict = r_verdict;

    a_nul_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && is_nul) |=> (r_state == ST_START && r_out_valid))
        else $error("NUL item did not restart recogniser or post verdict");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && is_nul && r_out_valid && i_stall))
        else $error("input stalled without a blocked verdict");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_verdict == V_VALID || o_verdict == V_INCOMPLETE ||
                     o_verdict == V_INVALID))
        else $error("verdict code out of range");

    a_held_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_char)))
        else $error("stalled input item lost");

endmodule

// File: sim/flv_verdict_checker.sv
`timescale 1ns / 100ps
// Verdict checker for the float literal validator: watches both channels,
// tracks the recogniser state per accepted character and compares verdicts.
// Depends on flv_pkg.
module flv_verdict_checker
    import flv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_character,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [1:0] i_verdict,
    output int         o_fail_count,
    output int         o_pending
);

    t_state   parse_state;
    t_verdict verdict_queue[$];

    function automatic t_state advance(t_state s, logic [7:0] c);
        logic digit;
        logic sign;
        logic dot;
        logic expo;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        sign  = (c == CH_PLUS) || (c == CH_MINUS);
        dot   = (c == CH_DOT);
        expo  = (c == CH_E_UC) || (c == CH_E_LC);
        case (s)
            ST_START: begin
                if (sign) return ST_SIGN;
                if (digit) return ST_INT;
                if (dot) return ST_DOT;
                return ST_DEAD;
            end
            ST_SIGN: begin
                if (digit) return ST_INT;
                if (dot) return ST_DOT;
                return ST_DEAD;
            end
            ST_INT: begin
                if (digit) return ST_INT;
                if (dot) return ST_FRAC;
                if (expo) return ST_EXP;
                return ST_DEAD;
            end
            ST_DOT:  return digit ? ST_FRAC : ST_DEAD;
            ST_FRAC: begin
                if (digit) return ST_FRAC;
                if (expo) return ST_EXP;
                return ST_DEAD;
            end
            ST_EXP: begin
                if (sign) return ST_EXPSIGN;
                return digit ? ST_EXPDIG : ST_DEAD;
            end
            ST_EXPSIGN, ST_EXPDIG: return digit ? ST_EXPDIG : ST_DEAD;
            default: return ST_DEAD;
        endcase
    endfunction

    function automatic t_verdict verdict_for(t_state s);
        if (s == ST_INT || s == ST_FRAC || s == ST_EXPDIG) return V_VALID;
        if (s == ST_EXP || s == ST_EXPSIGN) return V_INCOMPLETE;
        return V_INVALID;
    endfunction

    always @(posedge i_clk) begin
        t_verdict expected;
        if (!i_rst_n) begin
            parse_state = ST_START;
            verdict_queue.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (verdict_queue.size() == 0) begin
                    $error("verdict item with none expected: actual %0d", i_verdict);
                    o_fail_count++;
                end else begin
                    expected = verdict_queue.pop_front();
                    if (i_verdict !== expected) begin
                        $error("verdict mismatch: expected %0d, actual %0d",
                               expected, i_verdict);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                // NUL closes the string: verdict from the state reached so far
                if (i_character == CH_NUL) begin
                    verdict_queue.push_back(verdict_for(parse_state));
                    parse_state = ST_START;
                end else begin
                    parse_state = advance(parse_state, i_character);
                end
            end
        end
        o_pending = verdict_queue.size();
    end

endmodule

// File: sim/float_literal_validator_test.sv
`timescale 1ns / 100ps
// Testbench top for the float literal validator: drives strings of characters
// under several idle/stall mixes and gives the verdict.
// Depends on flv_pkg, float_literal_validator and flv_verdict_checker.
module float_literal_validator_test
    import flv_pkg::*;
();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_CHARS  = 200;
    localparam int HOLD_CYCLES  = 300;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_character;
    logic       o_valid;
    logic       i_stall;
    logic [1:0] o_verdict;

    int fail_count;
    int pending_verdicts;
    int cycle_count = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int chars_sent = 0;
    bit hold_request = 1'b0;
    logic [7:0] text_buf[$];

    float_literal_validator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_character (i_character),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_verdict   (o_verdict)
    );

    flv_verdict_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_character  (i_character),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_verdict    (o_verdict),
        .o_fail_count (fail_count),
        .o_pending    (pending_verdicts)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off once requested
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Called and returns at a falling edge; valid is left high so that
    // back-to-back items need no second assignment in one step.
    task automatic send_char(input logic [7:0] c);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_character <= c;
        do @(posedge i_clk); while (o_stall);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
        send_char(CH_NUL);
    endtask

    task automatic send_text();
        foreach (text_buf[i]) send_char(text_buf[i]);
        send_char(CH_NUL);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_verdicts != 0) @(negedge i_clk);
    endtask

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_sign();
        return $urandom_range(1) ? CH_PLUS : CH_MINUS;
    endfunction

    function automatic logic [7:0] rand_token();
        case ($urandom_range(5))
            0: return rand_sign();
            1: return CH_DOT;
            2: return $urandom_range(1) ? CH_E_UC : CH_E_LC;
            3: return rand_digit();
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // Mostly well-formed literals with random content; some broken, some noise
    task automatic build_literal();
        int kind;
        int n;
        int pos;
        kind = $urandom_range(99);
        text_buf.delete();
        if (kind < 8) begin
            n = $urandom_range(6);
            repeat (n) text_buf.push_back(8'($urandom_range(1, 255)));
            return;
        end
        if ($urandom_range(2) == 0) text_buf.push_back(rand_sign());
        case ($urandom_range(2))
            0: repeat ($urandom_range(1, 4)) text_buf.push_back(rand_digit());
            1: begin
                repeat ($urandom_range(1, 3)) text_buf.push_back(rand_digit());
                text_buf.push_back(CH_DOT);
                repeat ($urandom_range(3)) text_buf.push_back(rand_digit());
            end
            default: begin
                text_buf.push_back(CH_DOT);
                repeat ($urandom_range(1, 3)) text_buf.push_back(rand_digit());
            end
        endcase
        if ($urandom_range(1)) begin
            text_buf.push_back($urandom_range(1) ? CH_E_UC : CH_E_LC);
            if ($urandom_range(1)) text_buf.push_back(rand_sign());
            // zero exponent digits leaves the literal incomplete
            repeat ($urandom_range(3)) text_buf.push_back(rand_digit());
        end
        if (kind < 30) begin
            pos = $urandom_range(text_buf.size() - 1);
            case ($urandom_range(2))
                0: text_buf[pos] = 8'($urandom_range(1, 255));
                1: text_buf.insert(pos, rand_token());
                default: text_buf.delete(pos);
            endcase
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_character = CH_NUL;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty string, trailing dot, leading dot with exponent,
        // incomplete exponents, lone sign and dot, top byte into dead state
        send_str("");
        send_str("-7.");
        send_str(".5E+9");
        send_str("1e-");
        send_str("+.");
        send_char(8'hFF);
        send_char(CH_NUL);
        send_str("0.e");
        wait_idle();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 63; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 63; end
                default: begin gap_pct = 18; stall_pct = 18; end
            endcase
            chars_sent = 0;
            if (p == 0) begin
                // long receiver hold-off while short strings keep coming
                hold_request = 1'b1;
                repeat (10) begin
                    send_str("5");
                    send_str(".e");
                end
            end
            while (chars_sent < PHASE_CHARS) begin
                build_literal();
                send_text();
            end
            wait_idle();
        end

        gap_pct = 0;
        stall_pct = 0;
        wait_idle();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/flv_pkg.sv
hw/rtl/float_literal_validator.sv
sim/flv_verdict_checker.sv
sim/float_literal_validator_test.sv
